>>> rtl/trunc_poly_matrix_multiply_assert.svh
// assertion macros used by the rtl datapath
`ifndef TRUNC_POLY_MATRIX_MULTIPLY_ASSERT_SVH
`define TRUNC_POLY_MATRIX_MULTIPLY_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TPM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trunc_poly_matrix_multiply assertion failed");

// next-cycle implication
`define TPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trunc_poly_matrix_multiply assertion failed");

`endif

>>> rtl/tpm_pkg.sv
// shared constants, codes and types of the truncated polynomial matrix product
`default_nettype none
package tpm_pkg;

  localparam int COEFF_BITS     = 32;
  localparam int FRAC_BITS      = 30;
  localparam int DEF_MAX_DIM    = 16;
  localparam int DEF_MAX_DEGREE = 31;
  localparam int IDX_W          = 6;
  localparam int CMP_W          = 8;
  localparam int CFG_W          = 5;

  localparam logic [COEFF_BITS-1:0] COEFF_MAX = '1;

  localparam logic [1:0] CMD_WR_A = 2'd0;
  localparam logic [1:0] CMD_WR_B = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic REG_DIM    = 1'b0;
  localparam logic REG_DEGREE = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET    = 5'd16;
  localparam logic [CFG_W-1:0] DEGREE_RESET = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             load_entry;
    logic [CMP_W-1:0] dim;
    logic             issue;
    logic [IDX_W-1:0] m;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] d;
    logic             out_load;
    logic             out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
    logic in_range;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/tpm_ifs.sv
// valid/ready channel interfaces for command words and result words
`default_nettype none
interface tpm_in_if;
  import tpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [3:0]            row;
  logic [3:0]            col;
  logic [4:0]            degree;
  logic [COEFF_BITS-1:0] coeff_value;

  modport source (output valid, command, row, col, degree, coeff_value, input ready);
  modport sink (input valid, command, row, col, degree, coeff_value, output ready);
endinterface

interface tpm_out_if;
  import tpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [4:0]            out_degree;
  logic [COEFF_BITS-1:0] out_coeff;
  logic                  saturated;
  logic                  last;

  modport source (output valid, out_degree, out_coeff, saturated, last, input ready);
  modport sink (input valid, out_degree, out_coeff, saturated, last, output ready);
endinterface
`default_nettype wire

>>> rtl/tpm_ctrl.sv
// controller: config registers, loop counters and sequencing state machine
`default_nettype none
module tpm_ctrl #(
  parameter int MAX_DIM    = tpm_pkg::DEF_MAX_DIM,
  parameter int MAX_DEGREE = tpm_pkg::DEF_MAX_DEGREE
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  input  wire [1:0]                in_command,
  output logic                     in_ready,
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire [tpm_pkg::CFG_W-1:0] cfg_data,
  input  tpm_pkg::dp_status_t      stat,
  output tpm_pkg::dp_cmd_t         cmd
);
  import tpm_pkg::*;

  localparam int RW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW = $clog2(MAX_DEGREE + 1);

  ctrl_state_t      state, state_next;
  logic [CFG_W-1:0] cfg_dim;
  logic [CFG_W-1:0] cfg_degree;
  logic [RW-1:0]    dim_last, dim_last_next;
  logic [DW-1:0]    top, top_next;
  logic [RW-1:0]    m, m_next;
  logic [DW-1:0]    j, j_next;
  logic [DW-1:0]    d, d_next;
  logic             zero_entry, zero_entry_next;
  logic [CMP_W-1:0] dim_sat;
  logic [CMP_W-1:0] top_sat;

  // registers clamped to their legal ranges when a read starts
  assign dim_sat = (cfg_dim == '0) ? CMP_W'(1) :
                   ((CMP_W'(cfg_dim) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(cfg_dim));
  assign top_sat = (cfg_degree == '0) ? CMP_W'(1) :
                   ((CMP_W'(cfg_degree) > CMP_W'(MAX_DEGREE)) ? CMP_W'(MAX_DEGREE) :
                    CMP_W'(cfg_degree));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cfg_dim    <= DIM_RESET;
      cfg_degree <= DEGREE_RESET;
      dim_last   <= '0;
      top        <= '0;
      m          <= '0;
      j          <= '0;
      d          <= '0;
      zero_entry <= 1'b0;
    end else begin
      state      <= state_next;
      dim_last   <= dim_last_next;
      top        <= top_next;
      m          <= m_next;
      j          <= j_next;
      d          <= d_next;
      zero_entry <= zero_entry_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_DIM:    cfg_dim <= cfg_data;
          REG_DEGREE: cfg_degree <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  always_comb begin
    state_next      = state;
    dim_last_next   = dim_last;
    top_next        = top;
    m_next          = m;
    j_next          = j;
    d_next          = d;
    zero_entry_next = zero_entry;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.dim         = dim_sat;
    cmd.m           = IDX_W'(m);
    cmd.j           = IDX_W'(j);
    cmd.d           = IDX_W'(d);
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_command)
            CMD_WR_A: cmd.wr_a = 1'b1;
            CMD_WR_B: cmd.wr_b = 1'b1;
            CMD_READ: begin
              cmd.load_entry  = 1'b1;
              dim_last_next   = RW'(dim_sat - CMP_W'(1));
              top_next        = DW'(top_sat);
              m_next          = '0;
              j_next          = '0;
              d_next          = '0;
              zero_entry_next = !stat.in_range;
              state_next      = stat.in_range ? ST_ISSUE : ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (j == d) begin
          j_next = '0;
          if (m == dim_last) begin
            m_next     = '0;
            state_next = ST_DRAIN;
          end else begin
            m_next = m + RW'(1);
          end
        end else begin
          j_next = j + DW'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (d == top);
          if (d == top) begin
            state_next = ST_IDLE;
          end else begin
            d_next     = d + DW'(1);
            state_next = zero_entry ? ST_EMIT : ST_ISSUE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/tpm_datapath.sv
// datapath: coefficient stores, multiply-accumulate pipeline and output register
`default_nettype none
`include "trunc_poly_matrix_multiply_assert.svh"
module tpm_datapath #(
  parameter int MAX_DIM    = tpm_pkg::DEF_MAX_DIM,
  parameter int MAX_DEGREE = tpm_pkg::DEF_MAX_DEGREE
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire [3:0]                     in_row,
  input  wire [3:0]                     in_col,
  input  wire [4:0]                     in_degree,
  input  wire [tpm_pkg::COEFF_BITS-1:0] in_coeff,
  input  tpm_pkg::dp_cmd_t              cmd,
  output tpm_pkg::dp_status_t           stat,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [4:0]                    out_degree,
  output logic [tpm_pkg::COEFF_BITS-1:0] out_coeff,
  output logic                          out_sat,
  output logic                          out_last
);
  import tpm_pkg::*;

  localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = $clog2(MAX_DEGREE + 1);
  localparam int AW    = 2 * RW + DW;
  localparam int DEPTH = 1 << AW;
  localparam int CB    = COEFF_BITS;

  logic [CB-1:0]   mem_a [DEPTH];
  logic [CB-1:0]   mem_b [DEPTH];
  logic            wr_ok;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr_a;
  logic [AW-1:0]   rd_addr_b;
  logic [DW-1:0]   b_deg;
  logic [RW-1:0]   e_row;
  logic [RW-1:0]   e_col;
  logic            v1;
  logic            v2;
  logic [CB-1:0]   rd_a;
  logic [CB-1:0]   rd_b;
  logic [2*CB-1:0] prod;
  logic            p_ovf;
  logic [CB-1:0]   p_val;
  logic [CB:0]     sum;
  logic [CB-1:0]   acc;
  logic            acc_sat;

  // writes outside the physical store are dropped
  assign wr_ok   = (CMP_W'(in_row) < CMP_W'(MAX_DIM)) && (CMP_W'(in_col) < CMP_W'(MAX_DIM)) &&
                   (CMP_W'(in_degree) <= CMP_W'(MAX_DEGREE));
  assign wr_addr = {RW'(in_row), RW'(in_col), DW'(in_degree)};

  // truncated convolution: a[row][m][j] * b[m][col][d-j]
  assign b_deg     = cmd.d[DW-1:0] - cmd.j[DW-1:0];
  assign rd_addr_a = {e_row, cmd.m[RW-1:0], cmd.j[DW-1:0]};
  assign rd_addr_b = {cmd.m[RW-1:0], e_col, b_deg};

  always_ff @(posedge clk) begin
    if (cmd.wr_a && wr_ok) mem_a[wr_addr] <= in_coeff;
    if (cmd.wr_b && wr_ok) mem_b[wr_addr] <= in_coeff;
    if (cmd.issue) begin
      rd_a <= mem_a[rd_addr_a];
      rd_b <= mem_b[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      e_row <= RW'(in_row);
      e_col <= RW'(in_col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) prod <= rd_a * rd_b;
  end

  // product back to Q2.30 with clipping, then saturating add
  assign p_ovf = |prod[2*CB-1:CB+FRAC_BITS];
  assign p_val = p_ovf ? COEFF_MAX : prod[CB+FRAC_BITS-1:FRAC_BITS];
  assign sum   = {1'b0, acc} + {1'b0, p_val};

  always_ff @(posedge clk) begin
    if (cmd.load_entry || cmd.out_load) begin
      acc     <= '0;
      acc_sat <= 1'b0;
    end else if (v2) begin
      acc     <= sum[CB] ? COEFF_MAX : sum[CB-1:0];
      acc_sat <= acc_sat | p_ovf | sum[CB];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_degree <= 5'(cmd.d);
      out_coeff  <= acc;
      out_sat    <= acc_sat;
      out_last   <= cmd.out_last;
    end
  end

  assign stat.busy     = v1 | v2;
  assign stat.out_free = !out_valid || out_ready;
  assign stat.in_range = (CMP_W'(in_row) < cmd.dim) && (CMP_W'(in_col) < cmd.dim);

  `TPM_ASSERT_SAME(a_load_when_free, cmd.out_load, !out_valid || out_ready)
  `TPM_ASSERT_SAME(a_write_quiet, cmd.wr_a || cmd.wr_b, !v1 && !v2 && !cmd.issue)
  `TPM_ASSERT_SAME(a_conv_index, cmd.issue, cmd.j <= cmd.d)
  `TPM_ASSERT_SAME(a_sat_is_max, out_valid && out_sat, out_coeff == COEFF_MAX)
  `TPM_ASSERT_NEXT(a_load_clears, cmd.out_load, acc == '0 && !acc_sat)

endmodule
`default_nettype wire

>>> rtl/trunc_poly_matrix_multiply.sv
// top level: truncated polynomial matrix product, controller plus datapath
// write word: accepted when idle; no result
// read word: per degree, multiply-accumulate steps over (m, j) on the one shared
//   multiplier, then pipeline drain and output load; out-of-range entries
//   skip the multiply-accumulate and give zero coefficients for degrees 0..top
// reset clears control and sets dim 16, degree 31; stores stay undefined until written
`default_nettype none
module trunc_poly_matrix_multiply #(
  parameter int MAX_DIM    = tpm_pkg::DEF_MAX_DIM,
  parameter int MAX_DEGREE = tpm_pkg::DEF_MAX_DEGREE
) (
  input  wire                      clk,
  input  wire                      rst,
  tpm_in_if.sink                   in_chan,
  tpm_out_if.source                out_chan,
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire [tpm_pkg::CFG_W-1:0] cfg_data
);
  import tpm_pkg::*;

  // controller to datapath commands and status back
  dp_cmd_t    cmd;
  dp_status_t stat;

  // sequencer: idle takes a word, issue walks (m, j) for one degree,
  // drain waits for the mac pipeline, emit loads the output register
  tpm_ctrl #(
    .MAX_DIM    (MAX_DIM),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .cmd        (cmd)
  );

  // stores, read registers, product register, saturating accumulator;
  // the output register lets the next degree run while a word waits
  tpm_datapath #(
    .MAX_DIM    (MAX_DIM),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_row     (in_chan.row),
    .in_col     (in_chan.col),
    .in_degree  (in_chan.degree),
    .in_coeff   (in_chan.coeff_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_degree (out_chan.out_degree),
    .out_coeff  (out_chan.out_coeff),
    .out_sat    (out_chan.saturated),
    .out_last   (out_chan.last)
  );

endmodule
`default_nettype wire

>>> tb/tpm_checker.sv
// result checker: predicts product coefficients from observed words and compares results
`timescale 1ns / 100ps
module tpm_checker
  import tpm_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  tpm_in_if                in_mon,
  tpm_out_if               out_mon,
  input  wire              cfg_we,
  input  wire              cfg_index,
  input  wire [CFG_W-1:0]  cfg_data,
  output int unsigned      fail_count,
  output int unsigned      pending
);

  localparam int STORE_DEPTH  = DEF_MAX_DIM * DEF_MAX_DIM * (DEF_MAX_DEGREE + 1);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [4:0]            degree;
    logic [COEFF_BITS-1:0] coeff;
    logic                  saturated;
    logic                  last;
  } coef_word_t;

  logic [COEFF_BITS-1:0] a_coef [STORE_DEPTH];
  logic [COEFF_BITS-1:0] b_coef [STORE_DEPTH];
  logic [CFG_W-1:0]      dim_reg;
  logic [CFG_W-1:0]      degree_reg;
  coef_word_t            prod_coef_q [$];
  coef_word_t            got;
  coef_word_t            want;
  int unsigned           mismatches;

  function automatic int unsigned clamp_reg(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // one expected word per degree 0..top of entry (row, col)
  task automatic predict_product_entry(input logic [3:0] row, input logic [3:0] col);
    int unsigned             dim;
    int unsigned             top;
    int unsigned             d;
    int unsigned             m;
    int unsigned             j;
    int unsigned             k;
    logic [COEFF_BITS:0]     acc;
    logic [2*COEFF_BITS-1:0] prod;
    logic [COEFF_BITS+1:0]   part;
    logic [COEFF_BITS-1:0]   term;
    logic                    clip;
    coef_word_t              w;
    dim = clamp_reg(dim_reg, DEF_MAX_DIM);
    top = clamp_reg(degree_reg, DEF_MAX_DEGREE);
    for (d = 0; d <= top; d++) begin
      acc  = '0;
      clip = 1'b0;
      if (row < dim && col < dim) begin
        for (m = 0; m < dim; m++) begin
          for (j = 0; j <= d; j++) begin
            k    = d - j;
            prod = (2*COEFF_BITS)'(a_coef[{row, m[3:0], j[4:0]}]) *
                   (2*COEFF_BITS)'(b_coef[{m[3:0], col, k[4:0]}]);
            part = prod[2*COEFF_BITS-1:FRAC_BITS];
            // product truncated to q2.30, clipped above the largest code
            if (part[COEFF_BITS+1:COEFF_BITS] != 2'b00) begin
              term = COEFF_MAX;
              clip = 1'b1;
            end else begin
              term = part[COEFF_BITS-1:0];
            end
            acc = acc + term;
            if (acc[COEFF_BITS]) begin
              acc  = {1'b0, COEFF_MAX};
              clip = 1'b1;
            end
          end
        end
      end
      w.degree    = d[4:0];
      w.coeff     = acc[COEFF_BITS-1:0];
      w.saturated = clip;
      w.last      = (d == top);
      prod_coef_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dim_reg    = DIM_RESET;
      degree_reg = DEGREE_RESET;
      mismatches = 0;
      prod_coef_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DIM) dim_reg = cfg_data;
        else degree_reg = cfg_data;
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.command)
          CMD_WR_A: a_coef[{in_mon.row, in_mon.col, in_mon.degree}] = in_mon.coeff_value;
          CMD_WR_B: b_coef[{in_mon.row, in_mon.col, in_mon.degree}] = in_mon.coeff_value;
          CMD_READ: predict_product_entry(in_mon.row, in_mon.col);
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.degree    = out_mon.out_degree;
        got.coeff     = out_mon.out_coeff;
        got.saturated = out_mon.saturated;
        got.last      = out_mon.last;
        if (prod_coef_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result word: degree %0d coeff %h sat %b last %b",
                     got.degree, got.coeff, got.saturated, got.last);
        end else begin
          want = prod_coef_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result mismatch: expected degree %0d coeff %h sat %b last %b, got degree %0d coeff %h sat %b last %b",
                       want.degree, want.coeff, want.saturated, want.last,
                       got.degree, got.coeff, got.saturated, got.last);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= prod_coef_q.size();
  end

endmodule

>>> tb/tb_trunc_poly_matrix_multiply.sv
// testbench top: command words, configuration and result back-pressure for the matrix product
`timescale 1ns / 100ps
module tb_trunc_poly_matrix_multiply;
  import tpm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int STORE_DEPTH   = DEF_MAX_DIM * DEF_MAX_DIM * (DEF_MAX_DEGREE + 1);
  // watchdog limit; the run keeps to small sizes, even under long result stalls
  localparam int CYCLE_LIMIT   = 1_000_000;
  // a write is taken while the block is idle; this covers a trailing write before a register write
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 200;
  localparam int LONG_HOLD     = 600;

  // register settings per random phase, zero codes among them; sizes stay small
  // so that the store fill keeps the word count low
  localparam int NUM_PHASES = 6;
  localparam int PH_DIM   [NUM_PHASES] = '{2,  1, 0,  2, 1, 2};
  localparam int PH_DEG   [NUM_PHASES] = '{3,  1, 0,  5, 7, 2};
  localparam int PH_ITEMS [NUM_PHASES] = '{14, 6, 5,  8, 5, 6};
  localparam int PH_READ  [NUM_PHASES] = '{50, 40, 40, 35, 35, 30};
  localparam int PH_IDLE  [NUM_PHASES] = '{1,  1, 0,  1, 1, 0};

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             idle_on;
  logic             long_hold_req;
  int unsigned      fail_count;
  int unsigned      words_pending;
  int unsigned      cycle_count;

  // stimulus-side view of the settings and of which store words hold data
  int unsigned      dim_eff;
  int unsigned      top_eff;
  bit               src_idle;
  bit               a_set [STORE_DEPTH];
  bit               b_set [STORE_DEPTH];

  tpm_in_if  in_ch ();
  tpm_out_if out_ch ();

  trunc_poly_matrix_multiply u_top (
    .clk       (clk),
    .rst       (rst),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tpm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // result side: random gap after each word while idle_on is set, plus one long hold-off on request
  initial begin : result_sink
    int unsigned wait_left;
    int unsigned hold_left;
    bit          hold_done;
    wait_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (out_ch.valid && out_ch.ready)
        wait_left = idle_on ? $urandom_range(0, 15) : 0;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  function automatic int unsigned clamp_cfg(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // wide mix for random writes; mostly small values for the fill so that sums stay varied
  function automatic logic [COEFF_BITS-1:0] rand_coeff(input bit wide);
    int unsigned pick;
    pick = $urandom_range(0, wide ? 7 : 63);
    case (pick)
      0:       return '0;
      1:       return COEFF_MAX;
      2:       return 32'h4000_0000;
      3:       return $urandom;
      default: return $urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  // offer one word and return right after the edge that took it; valid stays high
  // when the next word follows with no gap
  task automatic send_word(input logic [1:0] cmd, input logic [3:0] row, input logic [3:0] col,
                           input logic [4:0] deg, input logic [COEFF_BITS-1:0] val,
                           input bit gappy);
    int unsigned gap;
    gap = gappy ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.row         <= row;
    in_ch.col         <= col;
    in_ch.degree      <= deg;
    in_ch.coeff_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == CMD_WR_A) a_set[{row, col, deg}] = 1'b1;
    if (cmd == CMD_WR_B) b_set[{row, col, deg}] = 1'b1;
  endtask

  // write every coefficient in use that was never written, back to back
  task automatic fill_in_use();
    int unsigned r;
    int unsigned c;
    int unsigned d;
    for (r = 0; r < dim_eff; r++)
      for (c = 0; c < dim_eff; c++)
        for (d = 0; d <= top_eff; d++) begin
          if (!a_set[{r[3:0], c[3:0], d[4:0]}])
            send_word(CMD_WR_A, r[3:0], c[3:0], d[4:0], rand_coeff(1'b0), 1'b0);
          if (!b_set[{r[3:0], c[3:0], d[4:0]}])
            send_word(CMD_WR_B, r[3:0], c[3:0], d[4:0], rand_coeff(1'b0), 1'b0);
        end
  endtask

  // registers only change with the block idle: no word pending and a trailing write done
  task automatic set_config(input logic [CFG_W-1:0] dim, input logic [CFG_W-1:0] deg,
                            input bit idle);
    in_ch.valid <= 1'b0;
    idle_on     <= idle;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DIM;
    cfg_data  <= dim;
    @(posedge clk);
    cfg_index <= REG_DEGREE;
    cfg_data  <= deg;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dim_eff  = clamp_cfg(dim, DEF_MAX_DIM);
    top_eff  = clamp_cfg(deg, DEF_MAX_DEGREE);
    src_idle = idle;
  endtask

  initial begin : command_source
    int unsigned      ph;
    int unsigned      i;
    int unsigned      pick;
    logic [1:0]       cmd;
    logic [3:0]       row;
    logic [3:0]       col;
    logic [4:0]       deg;
    logic [COEFF_BITS-1:0] val;

    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_WR_A;
    in_ch.row         <= '0;
    in_ch.col         <= '0;
    in_ch.degree      <= '0;
    in_ch.coeff_value <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_DIM;
    cfg_data          <= '0;
    idle_on           <= 1'b1;
    long_hold_req     <= 1'b0;
    dim_eff           = DEF_MAX_DIM;
    top_eff           = DEF_MAX_DEGREE;
    src_idle          = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part on a 2 x 2 product of degree 3
    set_config(5'd2, 5'd3, 1'b1);
    fill_in_use();
    // product overflow: largest code times largest code
    send_word(CMD_WR_A, 4'd0, 4'd0, 5'd0, COEFF_MAX, src_idle);
    send_word(CMD_WR_B, 4'd0, 4'd0, 5'd0, COEFF_MAX, src_idle);
    send_word(CMD_READ, 4'd0, 4'd0, 5'd0, '0, src_idle);
    // sum overflow with no product overflow: 1.5 * 1.5 twice
    send_word(CMD_WR_A, 4'd0, 4'd0, 5'd0, 32'h6000_0000, src_idle);
    send_word(CMD_WR_B, 4'd0, 4'd0, 5'd0, 32'h6000_0000, src_idle);
    send_word(CMD_WR_A, 4'd0, 4'd1, 5'd0, 32'h6000_0000, src_idle);
    send_word(CMD_WR_B, 4'd1, 4'd0, 5'd0, 32'h6000_0000, src_idle);
    send_word(CMD_READ, 4'd0, 4'd0, 5'd0, '0, src_idle);
    // writes stored outside the size in use must not show up in reads
    send_word(CMD_WR_A, 4'd15, 4'd15, 5'd31, COEFF_MAX, src_idle);
    send_word(CMD_WR_B, 4'd15, 4'd15, 5'd31, '0, src_idle);
    send_word(CMD_WR_A, 4'd0, 4'd1, 5'd31, COEFF_MAX, src_idle);
    // unused command, both with all fields set and all clear
    send_word(CMD_UNUSED, 4'd15, 4'd15, 5'd31, COEFF_MAX, src_idle);
    send_word(CMD_UNUSED, 4'd0, 4'd0, 5'd0, '0, src_idle);
    // reads outside the matrix give zeros
    send_word(CMD_READ, 4'd15, 4'd15, 5'd0, '0, src_idle);
    send_word(CMD_READ, 4'd2, 4'd0, 5'd0, '0, src_idle);
    send_word(CMD_READ, 4'd0, 4'd2, 5'd0, '0, src_idle);
    // degree and value fields are don't-care on reads
    send_word(CMD_READ, 4'd1, 4'd0, 5'd31, COEFF_MAX, src_idle);
    send_word(CMD_WR_A, 4'd1, 4'd1, 5'd3, 32'h0000_0001, src_idle);
    send_word(CMD_WR_B, 4'd1, 4'd1, 5'd0, 32'h4000_0000, src_idle);
    send_word(CMD_WR_A, 4'd1, 4'd0, 5'd0, '0, src_idle);
    send_word(CMD_READ, 4'd1, 4'd1, 5'd0, '0, src_idle);
    send_word(CMD_WR_A, 4'd0, 4'd1, 5'd3, 32'h3FFF_FFFF, src_idle);
    send_word(CMD_READ, 4'd0, 4'd1, 5'd0, '0, src_idle);

    // random phases: mostly in-range writes and reads, a few unused commands
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_config(PH_DIM[ph][CFG_W-1:0], PH_DEG[ph][CFG_W-1:0], PH_IDLE[ph] != 0);
      fill_in_use();
      // stall the result side long enough that the block backs up into its input
      if (ph == 0) long_hold_req <= 1'b1;
      for (i = 0; i < PH_ITEMS[ph]; i++) begin
        pick = $urandom_range(0, 99);
        deg  = 5'($urandom_range(0, 31));
        val  = rand_coeff(1'b1);
        if ($urandom_range(0, 3) != 0) begin
          row = 4'($urandom_range(0, dim_eff - 1));
          col = 4'($urandom_range(0, dim_eff - 1));
        end else begin
          row = 4'($urandom_range(0, 15));
          col = 4'($urandom_range(0, 15));
        end
        if (pick < PH_READ[ph]) begin
          cmd = CMD_READ;
        end else if (pick < 95) begin
          cmd = $urandom_range(0, 1) ? CMD_WR_B : CMD_WR_A;
          if ($urandom_range(0, 3) != 0) deg = 5'($urandom_range(0, top_eff));
        end else begin
          cmd = CMD_UNUSED;
        end
        send_word(cmd, row, col, deg, val, src_idle);
      end
    end

    // wait out every expected word, then a quiet stretch to catch strays
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tpm_pkg.sv
rtl/tpm_ifs.sv
rtl/tpm_ctrl.sv
rtl/tpm_datapath.sv
rtl/trunc_poly_matrix_multiply.sv
tb/tpm_checker.sv
tb/tb_trunc_poly_matrix_multiply.sv
